FILE: rtl/core/imcb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// imcb_pkg: shared types and constants of the interrupt balancer
// Transfer payloads, configuration register codes, cell commands and the
// default sizes of the counter array.
// ----------------------------------------------------------------------------
package imcb_pkg;

  localparam int MAX_CORES_DEF   = 16;
  localparam int IRQ_LINES_DEF   = 16;
  localparam int COUNT_WIDTH_DEF = 32;

  localparam int DIV_WIDTH   = 16;
  localparam int CFG_IDX_W   = 4;
  localparam int CFG_DATA_W  = 16;
  localparam int ACT_WIDTH   = 5;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BALANCE_ENABLE    = 4'd0,
    CFG_SYMMETRIC_IO_MODE = 4'd1,
    CFG_BALANCE_DIVISOR   = 4'd2,
    CFG_ACTIVE_CORES      = 4'd3
  } cfg_reg_e;

  typedef struct packed {
    logic [3:0] irq;
    logic [3:0] core;
    logic       balance_allowed;
  } in_item_t;

  typedef struct packed {
    logic       eoi_to_local_apic;
    logic       route_valid;
    logic [3:0] route_irq;
    logic [3:0] route_core;
    logic       counts_cleared;
  } out_item_t;

  typedef struct packed {
    logic rd;
    logic load;
    logic clr;
  } cell_cmd_t;

endpackage

FILE: rtl/core/imcb_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// imcb_ram: generic single write, single read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module imcb_ram #(
  parameter int Width = 32,
  parameter int Depth = 16,
  parameter int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/core/imcb_mod.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// imcb_mod: bit-serial remainder unit
// Restoring division that yields the remainder of a count by the divisor,
// one dividend bit per cycle.
// ----------------------------------------------------------------------------
module imcb_mod #(
  parameter int CountW = imcb_pkg::COUNT_WIDTH_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  input  logic [CountW-1:0]              dividend_i,
  input  logic [imcb_pkg::DIV_WIDTH-1:0] divisor_i,
  output logic                           busy_o,
  output logic                           zero_o
);
  import imcb_pkg::*;

  localparam int StepW = $clog2(CountW + 1);

  logic [DIV_WIDTH-1:0] rem_q, rem_d;
  logic [CountW-1:0]    dvd_q;
  logic [StepW-1:0]     step_q;
  logic                 busy_q;
  logic [DIV_WIDTH:0]   trial;
  logic [DIV_WIDTH:0]   diff;

  always_comb begin
    trial = {rem_q, dvd_q[CountW-1]};
    diff  = trial - {1'b0, divisor_i};
    rem_d = (trial >= {1'b0, divisor_i}) ? diff[DIV_WIDTH-1:0] : trial[DIV_WIDTH-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      step_q <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      step_q <= StepW'(CountW);
    end else if (busy_q) begin
      step_q <= step_q - 1'b1;
      if (step_q == StepW'(1)) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvd_q <= dividend_i;
      rem_q <= '0;
    end else if (busy_q) begin
      dvd_q <= dvd_q << 1;
      rem_q <= rem_d;
    end
  end

  assign busy_o = busy_q;
  assign zero_o = (rem_q == '0);

endmodule

FILE: rtl/core/imcb_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// imcb_cell: counter cell of one core
// Holds the per-irq counts of one core, updates the count of the handled
// irq and takes part in the least-count search passed along the row.
// ----------------------------------------------------------------------------
module imcb_cell #(
  parameter int CountW   = imcb_pkg::COUNT_WIDTH_DEF,
  parameter int IrqLines = imcb_pkg::IRQ_LINES_DEF,
  parameter int CoreW    = 4,
  parameter int Idx      = 0,
  parameter int IrqW     = (IrqLines > 1) ? $clog2(IrqLines) : 1
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  imcb_pkg::cell_cmd_t  cmd_i,
  input  logic [IrqW-1:0]      addr_i,
  input  logic                 own_i,
  input  logic                 clr_ok_i,
  input  logic [CountW-1:0]    best_i,
  input  logic [CoreW-1:0]     win_i,
  input  logic                 clear_i,
  output logic [CountW-1:0]    val_o,
  output logic [CountW-1:0]    best_o,
  output logic [CoreW-1:0]     win_o,
  output logic                 clear_o
);
  import imcb_pkg::*;

  localparam logic [CountW-1:0] NearMax = {{(CountW-1){1'b1}}, 1'b0};
  localparam logic [CoreW-1:0]  MyIdx   = CoreW'(Idx);

  logic [IrqLines-1:0] vld_q;
  logic                vld_rd_q;
  logic                nz0_q;
  logic [CountW-1:0]   val_q;
  logic [CountW-1:0]   rdata;
  logic [CountW-1:0]   rd_val;
  logic [CountW-1:0]   inc;
  logic                we;
  logic [CountW-1:0]   best_q, best_d;
  logic [CoreW-1:0]    win_q, win_d;
  logic                clear_q, clear_d;

  assign rd_val = vld_rd_q ? rdata : '0;
  assign inc    = rd_val + CountW'(1);
  assign we     = cmd_i.load && own_i;

  imcb_ram #(
    .Width (CountW),
    .Depth (IrqLines),
    .AddrW (IrqW)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (addr_i),
    .wdata_i (inc),
    .re_i    (cmd_i.rd),
    .raddr_i (addr_i),
    .rdata_o (rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      vld_rd_q <= 1'b0;
      nz0_q    <= 1'b0;
    end else begin
      if (cmd_i.rd) begin
        vld_rd_q <= vld_q[addr_i];
      end
      if (we) begin
        vld_q[addr_i] <= 1'b1;
        if (addr_i == '0) begin
          nz0_q <= (inc != '0);
        end
      end else if (cmd_i.clr && clr_ok_i) begin
        vld_q[addr_i] <= 1'b0;
        if (addr_i == '0) begin
          nz0_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      val_q <= own_i ? inc : rd_val;
    end
  end

  always_comb begin
    best_d  = best_i;
    win_d   = win_i;
    clear_d = clear_i;
    if (val_q < best_i) begin
      if (nz0_q) begin
        best_d = val_q;
        win_d  = MyIdx;
      end
    end else if (val_q >= NearMax) begin
      clear_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    best_q  <= best_d;
    win_q   <= win_d;
    clear_q <= clear_d;
  end

  assign val_o   = val_q;
  assign best_o  = best_q;
  assign win_o   = win_q;
  assign clear_o = clear_q;

endmodule

FILE: rtl/core/irq_min_count_balancer_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// irq_min_count_balancer_top: least-loaded interrupt routing
// Counts handled interrupts per core and irq; if balancing is on and allowed,
// every divisor-th one routes its irq to the least-count core that took irq 0.
//
//   channel  direction  handshake               payload
//   in       input      in_valid_i/in_ready_o   in_data_i (irq, core, allow)
//   out      output     out_valid_o/out_ready_i out_data_o (eoi, route, clear)
//   cfg      input      cfg_valid_i/cfg_ready_o cfg_index_i, cfg_data_i
//
// An item in range passes the read, load and check steps, then the output
// step. When the remainder check runs, the bit-serial remainder unit follows
// the check; a zero remainder then adds the search along the cell row and,
// when counts are cleared, a clear step.
// Reset clears all counts at once through per-entry valid bits.
// A new item is taken while a finished result still waits in the output
// register; a stalled output holds the next result in its last step.
// ----------------------------------------------------------------------------
module irq_min_count_balancer_top #(
  parameter int MAX_CORES   = imcb_pkg::MAX_CORES_DEF,
  parameter int IRQ_LINES   = imcb_pkg::IRQ_LINES_DEF,
  parameter int COUNT_WIDTH = imcb_pkg::COUNT_WIDTH_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  imcb_pkg::in_item_t              in_data_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output imcb_pkg::out_item_t             out_data_o,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [imcb_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [imcb_pkg::CFG_DATA_W-1:0] cfg_data_i
);
  import imcb_pkg::*;

  localparam int CoreW = $clog2(MAX_CORES);
  localparam int IrqW  = (IRQ_LINES > 1) ? $clog2(IRQ_LINES) : 1;
  localparam int ScanW = $clog2(MAX_CORES + 1);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_READ  = 3'd1;
  localparam logic [2:0] ST_LOAD  = 3'd2;
  localparam logic [2:0] ST_CHECK = 3'd3;
  localparam logic [2:0] ST_MOD   = 3'd4;
  localparam logic [2:0] ST_SCAN  = 3'd5;
  localparam logic [2:0] ST_CLEAR = 3'd6;
  localparam logic [2:0] ST_OUT   = 3'd7;

  logic [2:0]           state_q, state_d;
  in_item_t             item_q;
  logic                 rt_valid_q;
  logic [3:0]           rt_core_q;
  logic                 rt_clear_q;
  logic [ScanW-1:0]     scan_q;
  logic                 out_valid_q;
  out_item_t            out_q;

  logic                 bal_en_q;
  logic                 sym_io_q;
  logic [DIV_WIDTH-1:0] div_q;
  logic [ACT_WIDTH-1:0] act_q;

  logic [IrqW+3:0]      irq_ext;
  logic [CoreW+3:0]     core_ext;
  logic [IrqW-1:0]      addr;
  logic [CoreW-1:0]     core_idx;
  logic                 in_range;
  cell_cmd_t            cmd;
  logic [MAX_CORES-1:0] own;
  logic [MAX_CORES-1:0] clr_ok;
  logic [COUNT_WIDTH-1:0] vals [MAX_CORES];
  logic [COUNT_WIDTH-1:0] best_w [MAX_CORES+1];
  logic [CoreW-1:0]     win_w [MAX_CORES+1];
  logic [MAX_CORES:0]   clear_w;
  logic [COUNT_WIDTH-1:0] cnt;
  logic [CoreW+3:0]     win_ext;
  logic                 mod_start;
  logic                 mod_busy;
  logic                 mod_zero;
  logic                 out_load;

  assign irq_ext  = {{IrqW{1'b0}}, item_q.irq};
  assign core_ext = {{CoreW{1'b0}}, item_q.core};
  assign addr     = irq_ext[IrqW-1:0];
  assign core_idx = core_ext[CoreW-1:0];
  assign in_range = (irq_ext < (IrqW + 4)'(IRQ_LINES)) &&
                    (core_ext < (CoreW + 4)'(MAX_CORES));
  assign cnt      = vals[core_idx];
  assign win_ext  = {4'b0000, win_w[MAX_CORES]};

  assign cmd.rd   = (state_q == ST_READ) && in_range;
  assign cmd.load = (state_q == ST_LOAD);
  assign cmd.clr  = (state_q == ST_CLEAR);

  assign mod_start = (state_q == ST_CHECK) && item_q.balance_allowed && bal_en_q &&
                     (cnt != '0) && (div_q != '0);
  assign out_load  = (state_q == ST_OUT) && (!out_valid_q || out_ready_i);

  assign best_w[0]  = '1;
  assign win_w[0]   = '0;
  assign clear_w[0] = 1'b0;

  for (genvar i = 0; i < MAX_CORES; i++) begin : g_cell
    assign own[i]    = in_range && (core_idx == CoreW'(i));
    assign clr_ok[i] = (int'(act_q) > i);

    imcb_cell #(
      .CountW   (COUNT_WIDTH),
      .IrqLines (IRQ_LINES),
      .CoreW    (CoreW),
      .Idx      (i),
      .IrqW     (IrqW)
    ) u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .cmd_i    (cmd),
      .addr_i   (addr),
      .own_i    (own[i]),
      .clr_ok_i (clr_ok[i]),
      .best_i   (best_w[i]),
      .win_i    (win_w[i]),
      .clear_i  (clear_w[i]),
      .val_o    (vals[i]),
      .best_o   (best_w[i+1]),
      .win_o    (win_w[i+1]),
      .clear_o  (clear_w[i+1])
    );
  end

  imcb_mod #(
    .CountW (COUNT_WIDTH)
  ) u_mod (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (mod_start),
    .dividend_i (cnt),
    .divisor_i  (div_q),
    .busy_o     (mod_busy),
    .zero_o     (mod_zero)
  );

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = ST_READ;
        end
      end
      ST_READ: begin
        state_d = in_range ? ST_LOAD : ST_OUT;
      end
      ST_LOAD: begin
        state_d = ST_CHECK;
      end
      ST_CHECK: begin
        state_d = mod_start ? ST_MOD : ST_OUT;
      end
      ST_MOD: begin
        if (!mod_busy) begin
          state_d = mod_zero ? ST_SCAN : ST_OUT;
        end
      end
      ST_SCAN: begin
        if (scan_q == ScanW'(MAX_CORES - 1)) begin
          state_d = clear_w[MAX_CORES] ? ST_CLEAR : ST_OUT;
        end
      end
      ST_CLEAR: begin
        state_d = ST_OUT;
      end
      ST_OUT: begin
        if (out_load) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      scan_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_SCAN) begin
        scan_q <= scan_q + 1'b1;
      end else begin
        scan_q <= '0;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      item_q     <= in_data_i;
      rt_valid_q <= 1'b0;
      rt_core_q  <= '0;
      rt_clear_q <= 1'b0;
    end else if ((state_q == ST_SCAN) && (scan_q == ScanW'(MAX_CORES - 1))) begin
      rt_valid_q <= 1'b1;
      rt_core_q  <= win_ext[3:0];
      rt_clear_q <= clear_w[MAX_CORES];
    end
    if (out_load) begin
      out_q.eoi_to_local_apic <= sym_io_q;
      out_q.route_valid       <= rt_valid_q;
      out_q.route_irq         <= rt_valid_q ? item_q.irq : 4'd0;
      out_q.route_core        <= rt_core_q;
      out_q.counts_cleared    <= rt_clear_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bal_en_q <= 1'b0;
      sym_io_q <= 1'b0;
      div_q    <= DIV_WIDTH'(10);
      act_q    <= ACT_WIDTH'(1);
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_BALANCE_ENABLE:    bal_en_q <= cfg_data_i[0];
        CFG_SYMMETRIC_IO_MODE: sym_io_q <= cfg_data_i[0];
        CFG_BALANCE_DIVISOR:   div_q    <= cfg_data_i[DIV_WIDTH-1:0];
        CFG_ACTIVE_CORES:      act_q    <= cfg_data_i[ACT_WIDTH-1:0];
        default: begin
        end
      endcase
    end
  end

  assign in_ready_o  = (state_q == ST_IDLE);
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

`ifndef ASSERT_OFF
  a_accept_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> (state_q == ST_READ))
    else $error("accepted transfer did not start a read");

  a_clear_needs_route: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.counts_cleared) |-> out_data_o.route_valid)
    else $error("counts cleared without a routing decision");

  a_no_route_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_data_o.route_valid) |->
      ((out_data_o.route_irq == 4'd0) && (out_data_o.route_core == 4'd0)))
    else $error("route fields set without a routing decision");

  a_one_owner: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(own))
    else $error("more than one cell owns the item");

  a_clear_after_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CLEAR) |-> ($past(state_q) == ST_SCAN))
    else $error("clear step entered without a finished search");
`endif

endmodule

FILE: bench/irq_min_count_balancer_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// irq_min_count_balancer_top_tb: self-checking bench for least-loaded routing
// Handled interrupts are sent through the input channel while the sender and
// the receiver pause at random. A behavioural copy of the per-core counters
// and of the least-count search predicts each result, and every output
// transfer is compared field by field. The register settings change between
// phases, and each change is made only while the block is idle.
// ----------------------------------------------------------------------------
module irq_min_count_balancer_top_tb;
  import imcb_pkg::*;

  localparam int CLK_PERIOD = 8;
  localparam int NUM_CORES = MAX_CORES_DEF;
  localparam int NUM_IRQS = IRQ_LINES_DEF;
  localparam int CNT_W = COUNT_WIDTH_DEF;
  localparam logic [CNT_W-1:0] NEAR_FULL = {{(CNT_W-1){1'b1}}, 1'b0};
  localparam logic [CFG_IDX_W-1:0] UNMAPPED_REG = 4'd9;
  localparam int SETTLE_CYCLES = CNT_W + NUM_CORES + 8;
  localparam int STALL_LIMIT = 2000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  in_item_t in_data_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  out_item_t out_data_o;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;

  logic [CNT_W-1:0] irq_count [NUM_CORES][NUM_IRQS];
  logic bal_enable;
  logic sym_mode;
  logic [DIV_WIDTH-1:0] bal_divisor;
  logic [ACT_WIDTH-1:0] act_cores;

  in_item_t pending_irqs[$];
  out_item_t exp_routes[$];
  int send_gap_max = 0;
  int recv_stall_max = 0;
  int send_gap = 0;
  int recv_stall = 0;
  int mismatches = 0;
  int items_sent = 0;
  int results_seen = 0;
  int routes_seen = 0;
  int cfg_writes = 0;
  int idle_cycles = 0;

  irq_min_count_balancer_top uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  function automatic out_item_t route_for_interrupt(in_item_t it);
    out_item_t res;
    logic [CNT_W-1:0] cnt;
    logic [CNT_W-1:0] least;
    logic [CNT_W-1:0] v;
    logic clr;
    int win;
    int lim;
    res = '0;
    res.eoi_to_local_apic = sym_mode;
    cnt = irq_count[it.core][it.irq] + 1'b1;
    irq_count[it.core][it.irq] = cnt;
    if (it.balance_allowed && bal_enable && cnt != 0 && bal_divisor != 0 &&
        (cnt % bal_divisor) == 0) begin
      least = '1;
      win = 0;
      clr = 1'b0;
      for (int c = 0; c < NUM_CORES; c++) begin
        v = irq_count[c][it.irq];
        if (v < least) begin
          // A core that has never taken irq 0 cannot be chosen.
          if (irq_count[c][0] != 0) begin
            least = v;
            win = c;
          end
        end else if (v >= NEAR_FULL) begin
          clr = 1'b1;
        end
      end
      res.route_valid = 1'b1;
      res.route_irq = it.irq;
      res.route_core = 4'(win);
      if (clr) begin
        lim = (act_cores > NUM_CORES) ? NUM_CORES : int'(act_cores);
        for (int c = 0; c < lim; c++) irq_count[c][it.irq] = '0;
        res.counts_cleared = 1'b1;
      end
    end
    return res;
  endfunction

  task automatic check_field(string name, logic [3:0] want, logic [3:0] got);
    if (want !== got) begin
      mismatches++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : sender_p
    logic keep;
    int gap;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      send_gap <= 0;
    end else begin
      keep = in_valid_i;
      gap = send_gap;
      if (in_valid_i && in_ready_o) begin
        exp_routes.push_back(route_for_interrupt(in_data_i));
        items_sent++;
        keep = 1'b0;
        gap = $urandom_range(0, send_gap_max);
      end
      if (!keep) begin
        if (gap > 0) begin
          gap--;
        end else if (pending_irqs.size() != 0) begin
          in_data_i <= pending_irqs.pop_front();
          keep = 1'b1;
        end
      end
      in_valid_i <= keep;
      send_gap <= gap;
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin : receiver_p
    out_item_t want;
    int stall;
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      recv_stall <= 0;
    end else begin
      stall = recv_stall;
      if (out_valid_o && out_ready_i) begin
        results_seen++;
        if (out_data_o.route_valid) routes_seen++;
        if (exp_routes.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected result, expected none, actual %h", $time,
                   out_data_o);
        end else begin
          want = exp_routes.pop_front();
          check_field("eoi_to_local_apic", 4'(want.eoi_to_local_apic),
                      4'(out_data_o.eoi_to_local_apic));
          check_field("route_valid", 4'(want.route_valid),
                      4'(out_data_o.route_valid));
          check_field("route_irq", want.route_irq, out_data_o.route_irq);
          check_field("route_core", want.route_core, out_data_o.route_core);
          check_field("counts_cleared", 4'(want.counts_cleared),
                      4'(out_data_o.counts_cleared));
        end
        stall = $urandom_range(0, recv_stall_max);
      end
      if (stall > 0) begin
        stall--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
      recv_stall <= stall;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
          (cfg_valid_i && cfg_ready_o)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
        $display("%0t: no transfer for %0d cycles, %0d results outstanding", $time,
                 idle_cycles, exp_routes.size());
        $display("irq_min_count_balancer_top_tb: done, errors");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    cfg_writes++;
    case (idx)
      CFG_BALANCE_ENABLE:    bal_enable = val[0];
      CFG_SYMMETRIC_IO_MODE: sym_mode = val[0];
      CFG_BALANCE_DIVISOR:   bal_divisor = val[DIV_WIDTH-1:0];
      CFG_ACTIVE_CORES:      act_cores = val[ACT_WIDTH-1:0];
      default: ;
    endcase
  endtask

  task automatic drain();
    while (pending_irqs.size() != 0 || in_valid_i || exp_routes.size() != 0)
      @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic add_irq(logic [3:0] irq, logic [3:0] core, logic allowed);
    in_item_t it;
    it.irq = irq;
    it.core = core;
    it.balance_allowed = allowed;
    pending_irqs.push_back(it);
  endtask

  task automatic run_phase(logic en, logic sym, logic [DIV_WIDTH-1:0] div,
                           logic [ACT_WIDTH-1:0] act, int gap_max, int stall_max,
                           int hot_irqs, int n);
    in_item_t it;
    int pick;
    drain();
    write_reg(CFG_BALANCE_ENABLE, {15'($urandom), en});
    write_reg(CFG_SYMMETRIC_IO_MODE, {15'($urandom), sym});
    write_reg(CFG_BALANCE_DIVISOR, div);
    write_reg(CFG_ACTIVE_CORES, {11'($urandom), act});
    write_reg(UNMAPPED_REG, 16'($urandom));
    send_gap_max = gap_max;
    recv_stall_max = stall_max;
    for (int i = 0; i < n; i++) begin
      // Irq 0 is kept frequent so that cores become eligible as targets.
      pick = $urandom_range(0, 9);
      it.irq = (pick < 3) ? 4'd0 : 4'($urandom_range(0, (pick < 8) ? hot_irqs : 15));
      it.core = 4'($urandom_range(0, 15));
      it.balance_allowed = ($urandom_range(0, 7) != 0);
      pending_irqs.push_back(it);
    end
  endtask

  initial begin : stimulus_p
    for (int c = 0; c < NUM_CORES; c++)
      for (int q = 0; q < NUM_IRQS; q++) irq_count[c][q] = '0;
    bal_enable = 1'b0;
    sym_mode = 1'b0;
    bal_divisor = 16'd10;
    act_cores = 5'd1;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Settings from reset: balancing is off, so even the tenth count routes nothing.
    add_irq(4'd0, 4'd0, 1'b1);
    add_irq(4'd15, 4'd15, 1'b1);
    for (int i = 0; i < 10; i++) add_irq(4'd3, 4'd2, 1'b1);
    drain();
    write_reg(CFG_BALANCE_ENABLE, 16'd1);
    write_reg(CFG_SYMMETRIC_IO_MODE, 16'd1);
    write_reg(CFG_BALANCE_DIVISOR, 16'd1);
    write_reg(CFG_ACTIVE_CORES, 16'd16);

    // Only core 0 has taken irq 0 so far, so the first route must go to core 0.
    add_irq(4'd7, 4'd9, 1'b1);
    add_irq(4'd7, 4'd9, 1'b0);
    add_irq(4'd0, 4'd0, 1'b1);
    add_irq(4'd0, 4'd5, 1'b1);
    add_irq(4'd15, 4'd15, 1'b1);
    add_irq(4'd0, 4'd15, 1'b1);
    add_irq(4'd7, 4'd3, 1'b1);
    add_irq(4'd15, 4'd0, 1'b1);

    run_phase(1'b1, 1'b0, 16'd2, 5'd16, 13, 13, 3, 300);
    run_phase(1'b1, 1'b1, 16'd1, 5'd31, 0, 0, 3, 250);
    run_phase(1'b0, 1'b1, 16'd3, 5'd0, 13, 0, 7, 150);
    run_phase(1'b1, 1'b0, 16'd0, 5'd5, 0, 13, 3, 150);
    run_phase(1'b1, 1'b1, 16'hFFFF, 5'd1, 5, 5, 15, 100);
    run_phase(1'b1, 1'b0, 16'd3, 5'd8, 13, 13, 1, 350);
    run_phase(1'b1, 1'b1, 16'd7, 5'd16, 2, 13, 3, 300);
    drain();

    $display("Sent %0d handled interrupts and checked %0d results, %0d of them routes.",
             items_sent, results_seen, routes_seen);
    $display("Made %0d register writes, covering divisors from zero to full scale.",
             cfg_writes);
    if (mismatches == 0) begin
      $display("irq_min_count_balancer_top_tb: done, clean");
    end else begin
      $display("irq_min_count_balancer_top_tb: done, errors");
    end
    $finish;
  end

endmodule

FILE: irq_min_count_balancer_top.f
rtl/core/imcb_pkg.sv
rtl/core/imcb_ram.sv
rtl/core/imcb_mod.sv
rtl/core/imcb_cell.sv
rtl/core/irq_min_count_balancer_top.sv
bench/irq_min_count_balancer_top_tb.sv
